// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset is released.
`define RRTS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scheduler assertion failed");

// Checked at every rising edge, reset included.
`define RRTS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("scheduler assertion failed");

`endif

// ----- design/rrts_pkg.sv -----
// ---------------------------------------------------------------------------
// rrts_pkg
// Types and constants of the round-robin task slot scheduler.
// ---------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned DefTaskSlots  = 8;
  localparam logic [31:0] StackTopReset = 32'h2001_C000;
  localparam logic [16:0] StackGap      = 17'd64;
  localparam logic [31:0] FrameBytes    = 32'd32;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_START  = 2'd1,
    REQ_YIELD  = 2'd2,
    REQ_EXIT   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NO_FREE    = 3'd1,
    STS_NO_OTHER   = 3'd2,
    STS_NO_CURRENT = 3'd3,
    STS_NONE_READY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] stack_bytes;
  } rrts_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] task_id;
    logic [2:0]  new_slot;
    logic [2:0]  old_slot;
    logic        old_valid;
    logic [31:0] stack_pointer;
    logic [31:0] base_addr;
  } rrts_out_t;

  typedef struct packed {
    logic [31:0] task_id;
    logic [31:0] stack_pointer;
  } slot_entry_t;

endpackage

// ----- design/round_robin_task_slot_scheduler_core.sv -----
// ---------------------------------------------------------------------------
// round_robin_task_slot_scheduler_core
// Task slot table with create, start, yield and exit requests.
// ---------------------------------------------------------------------------
// Each request produces exactly one result. A create request goes through the
// slot scan, stack offset multiply, stack address add and table write, and
// result load into the output register; start, yield and exit go through the
// slot scan with a table read and the result load. The next request is
// accepted after the load. The slot scan uses find-first over the per-slot
// state flip-flops, twice for the round-robin pick of yield and exit; task ids
// and stack pointers live in a synchronous single-port-per-direction memory.
// A new request is accepted as soon as the previous result sits in the output
// register, even if that result is still stalled; a result waiting behind a
// stalled one holds the input off. No clearing pass is needed after reset.
module round_robin_task_slot_scheduler_core
  import rrts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = DefTaskSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rrts_in_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rrts_out_t   out_res_o
);

  `include "assert_macros.svh"

  localparam int unsigned SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned ProdW = SlotW + 17;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_CALC = 5'b01000,
    S_DONE = 5'b10000
  } fsm_e;

  function automatic logic [SlotW-1:0] find_first(input logic [TASK_SLOTS-1:0] vec);
    logic [TASK_SLOTS-1:0] lowest;
    logic [SlotW-1:0]      idx;
    lowest = vec & (~vec + TASK_SLOTS'(1));
    idx = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (lowest[i]) begin
        idx = idx | SlotW'(i);
      end
    end
    return idx;
  endfunction

  fsm_e                  state_q, state_d;
  logic [31:0]           stack_top_q;
  slot_state_e           slot_state_q [TASK_SLOTS];
  logic [SlotW-1:0]      cur_q, cur_d;
  logic                  cur_valid_q, cur_valid_d;
  logic [31:0]           next_id_q, next_id_d;
  req_e                  req_q;
  logic [15:0]           size_q;
  logic [SlotW-1:0]      slot_q;
  logic [ProdW-1:0]      prod_q;
  rrts_out_t             res_q;
  logic                  from_mem_q;
  rrts_out_t             out_res_q;
  logic                  out_valid_q, out_valid_d;
  rrts_out_t             load_res;

  slot_entry_t           slot_mem_q [TASK_SLOTS];
  slot_entry_t           rdata_q;

  logic [TASK_SLOTS-1:0] free_vec, ready_vec, running_vec, above_vec, ready_hi;
  logic [SlotW-1:0]      rr_slot;
  logic                  rr_found;

  // Decisions of the scan cycle.
  rrts_out_t             scan_res;
  logic [SlotW-1:0]      scan_slot;
  logic                  scan_rd, scan_create;
  logic                  upd0_en, upd1_en;
  logic [SlotW-1:0]      upd0_idx, upd1_idx;
  slot_state_e           upd0_val, upd1_val;

  logic [31:0]           calc_base, calc_sp;
  logic                  out_load;

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      free_vec[i]    = (slot_state_q[i] == SLOT_FREE);
      ready_vec[i]   = (slot_state_q[i] == SLOT_READY);
      running_vec[i] = (slot_state_q[i] == SLOT_RUNNING);
      above_vec[i]   = (i > int'(cur_q));
    end
  end

  // The running slot is never ready, so the ready set already excludes it.
  // Slots above the current one are searched first, then wrap to the bottom.
  assign ready_hi = ready_vec & above_vec;
  assign rr_found = |ready_vec;
  assign rr_slot  = (|ready_hi) ? find_first(ready_hi) : find_first(ready_vec);

  always_comb begin
    scan_res    = '0;
    scan_slot   = '0;
    scan_rd     = 1'b0;
    scan_create = 1'b0;
    upd0_en     = 1'b0;
    upd0_idx    = '0;
    upd0_val    = SLOT_FREE;
    upd1_en     = 1'b0;
    upd1_idx    = '0;
    upd1_val    = SLOT_FREE;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    next_id_d   = next_id_q;
    unique case (req_q)
      REQ_CREATE: begin
        if (|free_vec) begin
          scan_create       = 1'b1;
          scan_slot         = find_first(free_vec);
          scan_res.status   = STS_OK;
          scan_res.task_id  = next_id_q;
          scan_res.new_slot = 3'(scan_slot);
          next_id_d         = next_id_q + 32'd1;
          upd0_en           = 1'b1;
          upd0_idx          = scan_slot;
          upd0_val          = SLOT_READY;
        end else begin
          scan_res.status = STS_NO_FREE;
        end
      end
      REQ_START: begin
        if (cur_valid_q) begin
          scan_slot         = cur_q;
          scan_rd           = 1'b1;
          scan_res.status   = STS_OK;
          scan_res.new_slot = 3'(cur_q);
        end else if (|ready_vec) begin
          scan_slot         = find_first(ready_vec);
          scan_rd           = 1'b1;
          scan_res.status   = STS_OK;
          scan_res.new_slot = 3'(scan_slot);
          cur_d             = scan_slot;
          cur_valid_d       = 1'b1;
          upd0_en           = 1'b1;
          upd0_idx          = scan_slot;
          upd0_val          = SLOT_RUNNING;
        end else begin
          scan_res.status = STS_NONE_READY;
        end
      end
      REQ_YIELD: begin
        if (!cur_valid_q) begin
          scan_res.status = STS_NO_CURRENT;
        end else if (!rr_found) begin
          scan_res.status = STS_NO_OTHER;
        end else begin
          scan_slot          = rr_slot;
          scan_rd            = 1'b1;
          scan_res.status    = STS_OK;
          scan_res.new_slot  = 3'(rr_slot);
          scan_res.old_slot  = 3'(cur_q);
          scan_res.old_valid = 1'b1;
          cur_d              = rr_slot;
          upd0_en            = 1'b1;
          upd0_idx           = cur_q;
          upd0_val           = SLOT_READY;
          upd1_en            = 1'b1;
          upd1_idx           = rr_slot;
          upd1_val           = SLOT_RUNNING;
        end
      end
      REQ_EXIT: begin
        if (!cur_valid_q) begin
          scan_res.status = STS_NO_CURRENT;
        end else begin
          upd0_en  = 1'b1;
          upd0_idx = cur_q;
          upd0_val = SLOT_FREE;
          if (rr_found) begin
            scan_slot         = rr_slot;
            scan_rd           = 1'b1;
            scan_res.status   = STS_OK;
            scan_res.new_slot = 3'(rr_slot);
            cur_d             = rr_slot;
            upd1_en           = 1'b1;
            upd1_idx          = rr_slot;
            upd1_val          = SLOT_RUNNING;
          end else begin
            scan_res.status = STS_NONE_READY;
            cur_valid_d     = 1'b0;
          end
        end
      end
      default: begin
        scan_res.status = STS_NO_CURRENT;
      end
    endcase
  end

  assign calc_base = stack_top_q - 32'(prod_q);
  assign calc_sp   = calc_base + 32'(size_q) - FrameBytes;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Results of start, yield and exit take the id and stack pointer from the table.
  always_comb begin
    load_res = res_q;
    if (from_mem_q) begin
      load_res.task_id       = rdata_q.task_id;
      load_res.stack_pointer = rdata_q.stack_pointer;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_SCAN;
      S_SCAN: state_d = scan_create ? S_MUL : S_DONE;
      S_MUL:  state_d = S_CALC;
      S_CALC: state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stack_top_q <= StackTopReset;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      next_id_q   <= 32'd1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state_q[i] <= SLOT_FREE;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        stack_top_q <= cfg_wdata_i;
      end
      if (state_q == S_SCAN) begin
        cur_q       <= cur_d;
        cur_valid_q <= cur_valid_d;
        next_id_q   <= next_id_d;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (upd1_en && (upd1_idx == SlotW'(i))) begin
            slot_state_q[i] <= upd1_val;
          end else if (upd0_en && (upd0_idx == SlotW'(i))) begin
            slot_state_q[i] <= upd0_val;
          end
        end
      end
    end
  end

  // Request payload and result assembly.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      req_q  <= req_e'(in_req_i.req_type);
      size_q <= in_req_i.stack_bytes;
    end
    if (state_q == S_SCAN) begin
      res_q      <= scan_res;
      slot_q     <= scan_slot;
      from_mem_q <= scan_rd;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(slot_q) * ProdW'({1'b0, size_q} + StackGap);
    end
    if (state_q == S_CALC) begin
      res_q.stack_pointer <= calc_sp;
      res_q.base_addr     <= calc_base;
    end
    if (out_load) begin
      out_res_q <= load_res;
    end
  end

  // Slot table memory: written once per successful create, read in the scan cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      slot_mem_q[slot_q] <= '{task_id: res_q.task_id, stack_pointer: calc_sp};
    end
    if ((state_q == S_SCAN) && scan_rd) begin
      rdata_q <= slot_mem_q[scan_slot];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `RRTS_ASSERT(a_single_running, clk_i, rst_ni, $onehot0(running_vec))
  `RRTS_ASSERT(a_current_is_running, clk_i, rst_ni, cur_valid_q |-> running_vec[cur_q])
  `RRTS_ASSERT(a_idle_none_running, clk_i, rst_ni, !cur_valid_q |-> (running_vec == '0))

endmodule

// ----- test/round_robin_task_slot_scheduler_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// round_robin_task_slot_scheduler_core_tb
// A scoreboard predicts the result of each create, start, yield and exit
// request. It checks every result, field by field and in order. The stimulus
// is a directed run followed by three random phases, each under its own
// stack top setting and its own pattern of sender and receiver stalls.
// ---------------------------------------------------------------------------
module round_robin_task_slot_scheduler_core_tb
  import rrts_pkg::*;
;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned PhaseItems   = 250;

  class sched_scoreboard;
    slot_state_e slot_st[DefTaskSlots];
    logic [31:0] slot_task_id[DefTaskSlots];
    logic [31:0] slot_sp[DefTaskSlots];
    int          run_slot;
    bit          run_valid;
    logic [31:0] next_id;
    logic [31:0] stack_top;
    rrts_out_t   expected_q[$];
    int unsigned mismatches;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i] = SLOT_FREE;
      end
      run_slot   = 0;
      run_valid  = 1'b0;
      next_id    = 32'd1;
      stack_top  = StackTopReset;
      mismatches = 0;
    endfunction

    function void set_stack_top(logic [31:0] value);
      stack_top = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Round-robin scan for a ready slot, starting after the given one.
    function int find_ready_after(int from);
      int idx;
      for (int k = 1; k < DefTaskSlots; k++) begin
        idx = (from + k) % DefTaskSlots;
        if (slot_st[idx] == SLOT_READY) return idx;
      end
      return -1;
    endfunction

    function void note_request(rrts_in_t req);
      rrts_out_t   res;
      logic [31:0] base;
      int          slot;
      res  = '0;
      slot = -1;
      case (req.req_type)
        REQ_CREATE: begin
          for (int i = 0; i < DefTaskSlots; i++) begin
            if (slot < 0 && slot_st[i] == SLOT_FREE) slot = i;
          end
          if (slot < 0) begin
            res.status = STS_NO_FREE;
          end else begin
            base = stack_top - 32'(slot) * (32'(req.stack_bytes) + 32'(StackGap));
            slot_task_id[slot] = next_id;
            next_id            = next_id + 32'd1;
            slot_sp[slot]      = base + 32'(req.stack_bytes) - FrameBytes;
            slot_st[slot]      = SLOT_READY;
            res.status         = STS_OK;
            res.task_id        = slot_task_id[slot];
            res.new_slot       = 3'(slot);
            res.stack_pointer  = slot_sp[slot];
            res.base_addr      = base;
          end
        end
        REQ_START: begin
          if (!run_valid) begin
            for (int i = 0; i < DefTaskSlots; i++) begin
              if (!run_valid && slot_st[i] == SLOT_READY) begin
                run_slot   = i;
                run_valid  = 1'b1;
                slot_st[i] = SLOT_RUNNING;
              end
            end
          end
          if (run_valid) begin
            res.status        = STS_OK;
            res.task_id       = slot_task_id[run_slot];
            res.new_slot      = 3'(run_slot);
            res.stack_pointer = slot_sp[run_slot];
          end else begin
            res.status = STS_NONE_READY;
          end
        end
        default: begin
          if (!run_valid) begin
            res.status = STS_NO_CURRENT;
          end else if (req.req_type == REQ_YIELD) begin
            slot = find_ready_after(run_slot);
            if (slot < 0) begin
              res.status = STS_NO_OTHER;
            end else begin
              slot_st[run_slot] = SLOT_READY;
              slot_st[slot]     = SLOT_RUNNING;
              res.status        = STS_OK;
              res.task_id       = slot_task_id[slot];
              res.new_slot      = 3'(slot);
              res.old_slot      = 3'(run_slot);
              res.old_valid     = 1'b1;
              res.stack_pointer = slot_sp[slot];
              run_slot          = slot;
            end
          end else begin
            // The exiting task is freed; its context is never saved.
            slot_st[run_slot] = SLOT_FREE;
            slot = find_ready_after(run_slot);
            if (slot < 0) begin
              run_valid  = 1'b0;
              res.status = STS_NONE_READY;
            end else begin
              slot_st[slot]     = SLOT_RUNNING;
              res.status        = STS_OK;
              res.task_id       = slot_task_id[slot];
              res.new_slot      = 3'(slot);
              res.stack_pointer = slot_sp[slot];
              run_slot          = slot;
            end
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(rrts_out_t got);
      rrts_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no request outstanding: status %0d id %h",
                   $realtime, got.status, got.task_id);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.task_id !== want.task_id ||
          got.new_slot !== want.new_slot || got.old_slot !== want.old_slot ||
          got.old_valid !== want.old_valid ||
          got.stack_pointer !== want.stack_pointer ||
          got.base_addr !== want.base_addr) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected sts %0d id %h new %0d old %0d/%b sp %h base %h",
                   $realtime, want.status, want.task_id, want.new_slot,
                   want.old_slot, want.old_valid, want.stack_pointer,
                   want.base_addr);
          $display("%0t: actual   sts %0d id %h new %0d old %0d/%b sp %h base %h",
                   $realtime, got.status, got.task_id, got.new_slot,
                   got.old_slot, got.old_valid, got.stack_pointer,
                   got.base_addr);
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  rrts_in_t    in_req_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rrts_out_t   out_res_o;

  sched_scoreboard sb = new();

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 48;
  int unsigned cycle_count   = 0;
  logic        hold_active   = 1'b0;
  event        hold_off_go;

  round_robin_task_slot_scheduler_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("round_robin_task_slot_scheduler_core: mismatch");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_res_o);
    if (hold_active) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off so that the block backs up and stalls requests.
  always begin
    @(hold_off_go);
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  function automatic rrts_in_t make_request(req_e kind, logic [15:0] size);
    rrts_in_t req;
    req.req_type    = kind;
    req.stack_bytes = size;
    return req;
  endfunction

  task automatic send_request(input rrts_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  task automatic wait_all_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_stack_top(input logic [31:0] value);
    wait_all_results();
    // Let the block sit idle before the register write.
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_stack_top(value);
  endtask

  task automatic run_random_phase(input bit pause_mid, input bit hold_mid);
    rrts_in_t    req;
    int unsigned pick;
    for (int n = 0; n < PhaseItems; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) req.req_type = REQ_CREATE;
      else if (pick < 45) req.req_type = REQ_START;
      else if (pick < 80) req.req_type = REQ_YIELD;
      else req.req_type = REQ_EXIT;
      case ($urandom_range(9))
        0:       req.stack_bytes = 16'h0000;
        1:       req.stack_bytes = 16'hFFFF;
        default: req.stack_bytes = 16'($urandom);
      endcase
      if (hold_mid && n == 100) -> hold_off_go;
      send_request(req);
      if (pause_mid && n == PhaseItems / 2) begin
        in_valid_i <= 1'b0;
        wait_all_results();
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table first, then one task, then a full table.
    send_request(make_request(REQ_YIELD, 16'h0000));
    send_request(make_request(REQ_EXIT, 16'hFFFF));
    send_request(make_request(REQ_START, 16'h0000));
    send_request(make_request(REQ_CREATE, 16'h0000));
    send_request(make_request(REQ_START, 16'h0000));
    send_request(make_request(REQ_YIELD, 16'h0000));
    send_request(make_request(REQ_START, 16'h0000));
    send_request(make_request(REQ_EXIT, 16'h0000));
    send_request(make_request(REQ_CREATE, 16'hFFFF));
    send_request(make_request(REQ_CREATE, 16'h0001));
    send_request(make_request(REQ_CREATE, 16'h8000));
    send_request(make_request(REQ_CREATE, 16'h7FFF));
    send_request(make_request(REQ_CREATE, 16'h5555));
    send_request(make_request(REQ_CREATE, 16'hAAAA));
    send_request(make_request(REQ_CREATE, 16'hFFFF));
    send_request(make_request(REQ_CREATE, 16'h0020));
    send_request(make_request(REQ_CREATE, 16'h1234));
    send_request(make_request(REQ_START, 16'h0000));
    send_request(make_request(REQ_YIELD, 16'h0000));
    send_request(make_request(REQ_EXIT, 16'h0000));
    send_request(make_request(REQ_YIELD, 16'hFFFF));
    in_valid_i <= 1'b0;

    write_stack_top(32'h0000_0000);
    run_random_phase(1'b1, 1'b0);

    send_idle_pct = 48;
    recv_idle_pct = 22;
    write_stack_top(32'hFFFF_FFFF);
    run_random_phase(1'b0, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_stack_top(32'($urandom));
    run_random_phase(1'b0, 1'b0);

    wait_all_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("round_robin_task_slot_scheduler_core: match");
    end else begin
      $display("round_robin_task_slot_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/rrts_pkg.sv
design/round_robin_task_slot_scheduler_core.sv
test/round_robin_task_slot_scheduler_core_tb.sv
